// ===== hw/rtl/lwpc_pkg.sv =====
`default_nettype none
package lwpc_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CfgW    = 5;

  localparam logic [ModeW-1:0] MODE_GET   = 3'd0;
  localparam logic [ModeW-1:0] MODE_PUT   = 3'd1;
  localparam logic [ModeW-1:0] MODE_MARK  = 3'd2;
  localparam logic [ModeW-1:0] MODE_CLEAR = 3'd3;
  localparam logic [ModeW-1:0] MODE_LIST  = 3'd4;
  localparam logic [ModeW-1:0] MODE_FLUSH = 3'd5;

  localparam logic [StatusW-1:0] ST_HIT      = 4'd0;
  localparam logic [StatusW-1:0] ST_LOADED   = 4'd1;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 4'd2;
  localparam logic [StatusW-1:0] ST_PUTHIT   = 4'd3;
  localparam logic [StatusW-1:0] ST_PUTNEW   = 4'd4;
  localparam logic [StatusW-1:0] ST_MARKED   = 4'd5;
  localparam logic [StatusW-1:0] ST_CLEARED  = 4'd6;
  localparam logic [StatusW-1:0] ST_ABSENT   = 4'd7;
  localparam logic [StatusW-1:0] ST_EVICTWB  = 4'd8;
  localparam logic [StatusW-1:0] ST_DIRTY    = 4'd9;
  localparam logic [StatusW-1:0] ST_FLUSHWB  = 4'd10;
  localparam logic [StatusW-1:0] ST_END      = 4'd11;

  localparam logic [CfgW-1:0] CAP_RESET = 5'd16;

endpackage
`default_nettype wire

// ===== hw/rtl/lwpc_out_reg.sv =====
`default_nettype none
module lwpc_out_reg #(
  parameter int unsigned PW = 16,
  parameter int unsigned SW = 4,
  parameter int unsigned CW = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire logic [lwpc_pkg::StatusW-1:0] status_i,
  input  wire logic [PW-1:0]                page_i,
  input  wire logic [SW-1:0]                slot_i,
  input  wire logic [CW-1:0]                count_i,
  input  wire logic                         last_i,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [lwpc_pkg::StatusW-1:0]      status_o,
  output logic [PW-1:0]                     result_page_o,
  output logic [SW-1:0]                     slot_o,
  output logic [CW-1:0]                     dirty_count_o,
  output logic                              last_o
);

  logic                         valid_q, valid_d;
  logic [lwpc_pkg::StatusW-1:0] status_q;
  logic [PW-1:0]                page_q;
  logic [SW-1:0]                slot_q;
  logic [CW-1:0]                count_q;
  logic                         last_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      status_q <= status_i;
      page_q   <= page_i;
      slot_q   <= slot_i;
      count_q  <= count_i;
      last_q   <= last_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign status_o      = status_q;
  assign result_page_o = page_q;
  assign slot_o        = slot_q;
  assign dirty_count_o = count_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lwpc_ctrl.sv =====
`default_nettype none
module lwpc_ctrl #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAGE_ID_BITS = 16,
  parameter int unsigned SW           = 4,
  parameter int unsigned CW           = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [lwpc_pkg::CfgW-1:0]    cap_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [lwpc_pkg::ModeW-1:0]   mode_i,
  input  wire logic [PAGE_ID_BITS-1:0]      page_id_i,
  input  wire logic                         in_storage_i,
  output logic                              emit_valid_o,
  output logic [lwpc_pkg::StatusW-1:0]      emit_status_o,
  output logic [PAGE_ID_BITS-1:0]           emit_page_o,
  output logic [SW-1:0]                     emit_slot_o,
  output logic [CW-1:0]                     emit_count_o,
  output logic                              emit_last_o,
  input  wire logic                         emit_free_i
);

  localparam int unsigned PW = PAGE_ID_BITS;
  localparam int unsigned RW = SW;
  localparam int unsigned DW = PW + RW;
  localparam int unsigned EW = (CW > lwpc_pkg::CfgW) ? CW : lwpc_pkg::CfgW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EX    = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_EVCHK = 3'd4;
  localparam logic [2:0] S_EVWB  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [2:0] P_LOOK  = 3'd0;
  localparam logic [2:0] P_TOUCH = 3'd1;
  localparam logic [2:0] P_EVICT = 3'd2;
  localparam logic [2:0] P_INS   = 3'd3;
  localparam logic [2:0] P_WALK  = 3'd4;

  // entry store: page tag and recency rank per slot
  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rdata_q;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  logic [2:0]                   state_q, state_d, pass_q, pass_d;
  logic [SW-1:0]                idx_q, idx_d;
  logic [lwpc_pkg::ModeW-1:0]   mode_q, mode_d;
  logic [PW-1:0]                pg_q, pg_d;
  logic                         stor_q, stor_d;
  logic                         hit_q, hit_d;
  logic [SW-1:0]                hs_q, hs_d;
  logic [RW-1:0]                hr_q, hr_d;
  logic                         found_q, found_d;
  logic [SW-1:0]                vic_q, vic_d;
  logic [PW-1:0]                vpage_q, vpage_d;
  logic                         freef_q, freef_d;
  logic [SW-1:0]                free_q, free_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [lwpc_pkg::StatusW-1:0] fst_q, fst_d;
  logic [SW-1:0]                fslot_q, fslot_d;
  logic [CAPACITY-1:0]          valid_q, valid_d, dirty_q, dirty_d;
  logic [CW-1:0]                occ_q, occ_d;

  logic [PW-1:0] rpage;
  logic [RW-1:0] rrank;
  logic          vld, drt, last_idx, adv;
  logic [EW-1:0] cap_eff, occ_ext;

  assign rpage    = rdata_q[DW-1:RW];
  assign rrank    = rdata_q[RW-1:0];
  assign vld      = valid_q[idx_q];
  assign drt      = dirty_q[idx_q];
  assign last_idx = (idx_q == SW'(CAPACITY - 1));
  assign occ_ext  = EW'(occ_q);

  always_comb begin
    cap_eff = EW'(cap_i);
    if (cap_eff == '0) begin
      cap_eff = EW'(1);
    end else if (cap_eff > EW'(CAPACITY)) begin
      cap_eff = EW'(CAPACITY);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;  pass_d  = pass_q;   idx_d   = idx_q;
    mode_d  = mode_q;   pg_d    = pg_q;     stor_d  = stor_q;
    hit_d   = hit_q;    hs_d    = hs_q;     hr_d    = hr_q;
    found_d = found_q;  vic_d   = vic_q;    vpage_d = vpage_q;
    freef_d = freef_q;  free_d  = free_q;   cnt_d   = cnt_q;
    fst_d   = fst_q;    fslot_d = fslot_q;  valid_d = valid_q;
    dirty_d = dirty_q;  occ_d   = occ_q;
    mem_we        = 1'b0;
    mem_waddr     = idx_q;
    mem_wdata     = rdata_q;
    emit_valid_o  = 1'b0;
    emit_status_o = lwpc_pkg::ST_END;
    emit_page_o   = pg_q;
    emit_slot_o   = '0;
    emit_count_o  = '0;
    emit_last_o   = 1'b0;
    adv           = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          pg_d    = page_id_i;
          stor_d  = in_storage_i;
          hit_d   = 1'b0;
          cnt_d   = '0;
          idx_d   = '0;
          fslot_d = '0;
          case (mode_i)
            lwpc_pkg::MODE_GET, lwpc_pkg::MODE_PUT,
            lwpc_pkg::MODE_MARK, lwpc_pkg::MODE_CLEAR: begin
              pass_d  = P_LOOK;
              state_d = S_RD;
            end
            lwpc_pkg::MODE_LIST, lwpc_pkg::MODE_FLUSH: begin
              pass_d  = P_WALK;
              state_d = S_RD;
            end
            default: begin
              fst_d   = lwpc_pkg::ST_END;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_EX;
      end
      S_EX: begin
        case (pass_q)
          P_LOOK: begin
            if (vld && rpage == pg_q) begin
              hit_d = 1'b1;
              hs_d  = idx_q;
              hr_d  = rrank;
            end
          end
          P_TOUCH: begin
            if (vld) begin
              if (idx_q == hs_q) begin
                mem_we    = 1'b1;
                mem_wdata = {rpage, {RW{1'b0}}};
              end else if (rrank < hr_q) begin
                mem_we    = 1'b1;
                mem_wdata = {rpage, rrank + RW'(1)};
              end
            end
          end
          P_EVICT: begin
            if (vld && CW'(rrank) == occ_q - CW'(1)) begin
              found_d = 1'b1;
              vic_d   = idx_q;
              vpage_d = rpage;
            end
          end
          P_INS: begin
            if (vld) begin
              mem_we    = 1'b1;
              mem_wdata = {rpage, rrank + RW'(1)};
            end else if (!freef_q) begin
              freef_d = 1'b1;
              free_d  = idx_q;
            end
          end
          default: begin
            if (vld && drt) begin
              if (emit_free_i) begin
                emit_valid_o  = 1'b1;
                emit_status_o = (mode_q == lwpc_pkg::MODE_LIST) ?
                                lwpc_pkg::ST_DIRTY : lwpc_pkg::ST_FLUSHWB;
                emit_page_o   = rpage;
                emit_slot_o   = idx_q;
                cnt_d         = cnt_q + CW'(1);
                if (mode_q == lwpc_pkg::MODE_FLUSH) begin
                  dirty_d[idx_q] = 1'b0;
                end
              end else begin
                adv = 1'b0;
              end
            end
          end
        endcase
        if (adv) begin
          if (last_idx) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q + SW'(1);
            state_d = S_RD;
          end
        end
      end
      S_FIN: begin
        idx_d = '0;
        case (pass_q)
          P_LOOK: begin
            if (hit_q) begin
              fslot_d = hs_q;
              pass_d  = P_TOUCH;
              state_d = S_RD;
              case (mode_q)
                lwpc_pkg::MODE_GET: fst_d = lwpc_pkg::ST_HIT;
                lwpc_pkg::MODE_PUT: begin
                  fst_d = lwpc_pkg::ST_PUTHIT;
                  dirty_d[hs_q] = 1'b1;
                end
                lwpc_pkg::MODE_MARK: begin
                  fst_d = lwpc_pkg::ST_MARKED;
                  dirty_d[hs_q] = 1'b1;
                end
                default: begin
                  // clear keeps recency as is
                  fst_d = lwpc_pkg::ST_CLEARED;
                  dirty_d[hs_q] = 1'b0;
                  state_d = S_DONE;
                end
              endcase
            end else if (mode_q == lwpc_pkg::MODE_PUT ||
                         (mode_q == lwpc_pkg::MODE_GET && stor_q)) begin
              state_d = S_EVCHK;
            end else begin
              fst_d   = (mode_q == lwpc_pkg::MODE_GET) ?
                        lwpc_pkg::ST_NOTFOUND : lwpc_pkg::ST_ABSENT;
              state_d = S_DONE;
            end
          end
          P_TOUCH: begin
            state_d = S_DONE;
          end
          P_EVICT: begin
            if (found_q) begin
              state_d = S_EVWB;
            end else begin
              pass_d  = P_INS;
              freef_d = 1'b0;
              state_d = S_RD;
            end
          end
          P_INS: begin
            fst_d = (mode_q == lwpc_pkg::MODE_PUT) ?
                    lwpc_pkg::ST_PUTNEW : lwpc_pkg::ST_LOADED;
            if (freef_q) begin
              mem_we          = 1'b1;
              mem_waddr       = free_q;
              mem_wdata       = {pg_q, {RW{1'b0}}};
              valid_d[free_q] = 1'b1;
              dirty_d[free_q] = (mode_q == lwpc_pkg::MODE_PUT);
              occ_d           = occ_q + CW'(1);
              fslot_d         = free_q;
            end
            state_d = S_DONE;
          end
          default: begin
            fst_d   = lwpc_pkg::ST_END;
            state_d = S_DONE;
          end
        endcase
      end
      S_EVCHK: begin
        idx_d = '0;
        if (occ_ext >= cap_eff && occ_q != '0) begin
          pass_d  = P_EVICT;
          found_d = 1'b0;
        end else begin
          pass_d  = P_INS;
          freef_d = 1'b0;
        end
        state_d = S_RD;
      end
      S_EVWB: begin
        if (!dirty_q[vic_q] || emit_free_i) begin
          if (dirty_q[vic_q]) begin
            emit_valid_o  = 1'b1;
            emit_status_o = lwpc_pkg::ST_EVICTWB;
            emit_page_o   = vpage_q;
            emit_slot_o   = vic_q;
          end
          valid_d[vic_q] = 1'b0;
          dirty_d[vic_q] = 1'b0;
          occ_d          = occ_q - CW'(1);
          state_d        = S_EVCHK;
        end
      end
      S_DONE: begin
        if (emit_free_i) begin
          emit_valid_o  = 1'b1;
          emit_status_o = fst_q;
          emit_page_o   = pg_q;
          emit_slot_o   = fslot_q;
          emit_count_o  = cnt_q;
          emit_last_o   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      dirty_q <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q  <= pass_d;   idx_q   <= idx_d;    mode_q  <= mode_d;
    pg_q    <= pg_d;     stor_q  <= stor_d;   hit_q   <= hit_d;
    hs_q    <= hs_d;     hr_q    <= hr_d;     found_q <= found_d;
    vic_q   <= vic_d;    vpage_q <= vpage_d;  freef_q <= freef_d;
    free_q  <= free_d;   cnt_q   <= cnt_d;    fst_q   <= fst_d;
    fslot_q <= fslot_d;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lru_writeback_page_cache_top.sv =====
// fully associative page cache manager, lru replacement, dirty mark per entry
// input channel: mode_i, page_id_i, in_storage_i with in_valid_i / in_stall_o;
// one request is taken at a time, in_stall_o is high while it is in work
// output channel: status_o, result_page_o, slot_o, dirty_count_o, last_o with
// out_valid_o / out_stall_i; a request gives zero or more eviction or walk
// beats and then one beat with last_o high
// cfg_we_i writes capacity_in_use from cfg_wdata_i; the user must do so only
// while idle; the block does not enforce it. Entry tags and ranks sit in one
// single-port-read memory; every pass walks all CAPACITY slots (read, then
// modify and write back); get/put/mark hit: lookup pass plus recency pass
// clear, not found, absent: lookup pass only
// insertion: lookup pass, one pass per eviction, then insert pass
// list and flush: one pass over all slots
// a stalled receiver holds the output register and pauses the walk
// reset empties the cache and sets capacity_in_use to 16; no clearing sweep
`default_nettype none
module lru_writeback_page_cache_top #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAGE_ID_BITS = 16,
  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lwpc_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [lwpc_pkg::ModeW-1:0]   mode_i,
  input  wire logic [PAGE_ID_BITS-1:0]      page_id_i,
  input  wire logic                         in_storage_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [lwpc_pkg::StatusW-1:0]      status_o,
  output logic [PAGE_ID_BITS-1:0]           result_page_o,
  output logic [SW-1:0]                     slot_o,
  output logic [CW-1:0]                     dirty_count_o,
  output logic                              last_o
);

  logic [lwpc_pkg::CfgW-1:0]    cap_q;
  logic                         emit_valid, emit_last, emit_free;
  logic [lwpc_pkg::StatusW-1:0] emit_status;
  logic [PAGE_ID_BITS-1:0]      emit_page;
  logic [SW-1:0]                emit_slot;
  logic [CW-1:0]                emit_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lwpc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  lwpc_ctrl #(
    .CAPACITY    (CAPACITY),
    .PAGE_ID_BITS(PAGE_ID_BITS),
    .SW          (SW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .page_id_i    (page_id_i),
    .in_storage_i (in_storage_i),
    .emit_valid_o (emit_valid),
    .emit_status_o(emit_status),
    .emit_page_o  (emit_page),
    .emit_slot_o  (emit_slot),
    .emit_count_o (emit_count),
    .emit_last_o  (emit_last),
    .emit_free_i  (emit_free)
  );

  lwpc_out_reg #(
    .PW(PAGE_ID_BITS),
    .SW(SW),
    .CW(CW)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit_valid),
    .status_i     (emit_status),
    .page_i       (emit_page),
    .slot_i       (emit_slot),
    .count_i      (emit_count),
    .last_i       (emit_last),
    .free_o       (emit_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .result_page_o(result_page_o),
    .slot_o       (slot_o),
    .dirty_count_o(dirty_count_o),
    .last_o       (last_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted but block not busy");

  a_count_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != lwpc_pkg::ST_END |-> dirty_count_o == '0)
    else $error("dirty count on a non-end beat");

  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == lwpc_pkg::ST_NOTFOUND ||
                    status_o == lwpc_pkg::ST_ABSENT ||
                    status_o == lwpc_pkg::ST_END) |-> slot_o == '0)
    else $error("slot not zero on a miss or end beat");

  a_walk_beat_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == lwpc_pkg::ST_EVICTWB ||
                    status_o == lwpc_pkg::ST_DIRTY ||
                    status_o == lwpc_pkg::ST_FLUSHWB) |-> !last_o)
    else $error("eviction or walk beat marked last");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned NSLOT = 16;

  typedef struct packed {
    logic [lwpc_pkg::StatusW-1:0] status;
    logic [15:0]                  page;
    logic [3:0]                   slot;
    logic [4:0]                   count;
    logic                         last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lwpc_pkg::CfgW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [lwpc_pkg::ModeW-1:0] mode_i = lwpc_pkg::MODE_GET;
  logic [15:0] page_id_i = '0;
  logic in_storage_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [lwpc_pkg::StatusW-1:0] status_o;
  logic [15:0] result_page_o;
  logic [3:0] slot_o;
  logic [4:0] dirty_count_o;
  logic last_o;

  lru_writeback_page_cache_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .page_id_i(page_id_i), .in_storage_i(in_storage_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .result_page_o(result_page_o), .slot_o(slot_o),
    .dirty_count_o(dirty_count_o), .last_o(last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow cache state
  logic [15:0] sh_page[NSLOT];
  logic        sh_valid[NSLOT];
  logic        sh_dirty[NSLOT];
  int unsigned sh_rank[NSLOT];
  int unsigned sh_occ;
  int unsigned sh_cap;

  beat_t expected_beats[$];
  int unsigned n_errors = 0;
  int unsigned n_beats = 0;
  int unsigned n_items = 0;
  bit idle_on = 1'b1;
  bit hold_rx = 1'b0;
  logic [15:0] hot_pages[8];

  function automatic void push_beat(logic [3:0] st, logic [15:0] pg, int unsigned sl,
                                    int unsigned cnt, logic lst);
    beat_t b;
    b.status = st; b.page = pg; b.slot = sl[3:0]; b.count = cnt[4:0]; b.last = lst;
    expected_beats.push_back(b);
  endfunction

  function automatic int lookup_slot(logic [15:0] pg);
    for (int i = 0; i < NSLOT; i++)
      if (sh_valid[i] && sh_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic void promote(int s);
    int unsigned r;
    r = sh_rank[s];
    for (int i = 0; i < NSLOT; i++)
      if (sh_valid[i] && i != s && sh_rank[i] < r) sh_rank[i]++;
    sh_rank[s] = 0;
  endfunction

  function automatic void evict_for_room();
    int v;
    int unsigned c;
    c = (sh_cap < 1) ? 1 : ((sh_cap > NSLOT) ? NSLOT : sh_cap);
    while (sh_occ >= c && sh_occ > 0) begin
      v = -1;
      for (int i = 0; i < NSLOT; i++)
        if (v < 0 && sh_valid[i] && sh_rank[i] == sh_occ - 1) v = i;
      if (v < 0) break;
      if (sh_dirty[v]) push_beat(lwpc_pkg::ST_EVICTWB, sh_page[v], v, 0, 1'b0);
      sh_valid[v] = 1'b0;
      sh_dirty[v] = 1'b0;
      sh_occ--;
    end
  endfunction

  function automatic int place_page(logic [15:0] pg, logic d);
    int s;
    s = -1;
    for (int i = 0; i < NSLOT; i++)
      if (s < 0 && !sh_valid[i]) s = i;
    if (s < 0) return 0;
    for (int i = 0; i < NSLOT; i++)
      if (sh_valid[i]) sh_rank[i]++;
    sh_valid[s] = 1'b1; sh_dirty[s] = d; sh_page[s] = pg; sh_rank[s] = 0;
    sh_occ++;
    return s;
  endfunction

  function automatic void predict_request(logic [2:0] md, logic [15:0] pg, logic stor);
    int s;
    int unsigned cnt;
    s = lookup_slot(pg);
    cnt = 0;
    case (md)
      lwpc_pkg::MODE_GET: begin
        if (s >= 0) begin
          promote(s); push_beat(lwpc_pkg::ST_HIT, pg, s, 0, 1'b1);
        end else if (stor) begin
          evict_for_room(); s = place_page(pg, 1'b0);
          push_beat(lwpc_pkg::ST_LOADED, pg, s, 0, 1'b1);
        end else begin
          push_beat(lwpc_pkg::ST_NOTFOUND, pg, 0, 0, 1'b1);
        end
      end
      lwpc_pkg::MODE_PUT: begin
        if (s >= 0) begin
          sh_dirty[s] = 1'b1; promote(s);
          push_beat(lwpc_pkg::ST_PUTHIT, pg, s, 0, 1'b1);
        end else begin
          evict_for_room(); s = place_page(pg, 1'b1);
          push_beat(lwpc_pkg::ST_PUTNEW, pg, s, 0, 1'b1);
        end
      end
      lwpc_pkg::MODE_MARK: begin
        if (s >= 0) begin
          sh_dirty[s] = 1'b1; promote(s);
          push_beat(lwpc_pkg::ST_MARKED, pg, s, 0, 1'b1);
        end else push_beat(lwpc_pkg::ST_ABSENT, pg, 0, 0, 1'b1);
      end
      lwpc_pkg::MODE_CLEAR: begin
        if (s >= 0) begin
          sh_dirty[s] = 1'b0; push_beat(lwpc_pkg::ST_CLEARED, pg, s, 0, 1'b1);
        end else push_beat(lwpc_pkg::ST_ABSENT, pg, 0, 0, 1'b1);
      end
      lwpc_pkg::MODE_LIST, lwpc_pkg::MODE_FLUSH: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_dirty[i]) begin
            push_beat((md == lwpc_pkg::MODE_LIST) ? lwpc_pkg::ST_DIRTY : lwpc_pkg::ST_FLUSHWB,
                      sh_page[i], i, 0, 1'b0);
            if (md == lwpc_pkg::MODE_FLUSH) sh_dirty[i] = 1'b0;
            cnt++;
          end
        push_beat(lwpc_pkg::ST_END, pg, 0, cnt, 1'b1);
      end
      default: push_beat(lwpc_pkg::ST_END, pg, 0, 0, 1'b1);
    endcase
  endfunction

  // valid stays up after a request is taken until the next request or a drain drops it
  task automatic send_request(logic [2:0] md, logic [15:0] pg, logic stor);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i <= md; page_id_i <= pg; in_storage_i <= stor; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(md, pg, stor);
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    // a clean eviction-free request may still be winding down
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_capacity(int unsigned c);
    wait_drained();
    cfg_wdata_i <= c[4:0]; cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_cap = c[4:0];
  endtask

  // receiver stall process
  initial begin
    int len;
    forever begin
      @(posedge clk_i);
      if (hold_rx) out_stall_i <= 1'b1;
      else if (idle_on && $urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (len - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall_i <= hold_rx;
      end else out_stall_i <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_beats++;
      if (expected_beats.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected beat: status %0d page %h", status_o,
                                     result_page_o);
      end else begin
        e = expected_beats.pop_front();
        if (status_o !== e.status || result_page_o !== e.page || slot_o !== e.slot ||
            dirty_count_o !== e.count || last_o !== e.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp st%0d pg%h sl%0d n%0d l%0d got st%0d pg%h sl%0d n%0d l%0d",
                     e.status, e.page, e.slot, e.count, e.last, status_o, result_page_o,
                     slot_o, dirty_count_o, last_o);
        end
      end
    end
  end

  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return lwpc_pkg::MODE_GET;
    if (r < 60) return lwpc_pkg::MODE_PUT;
    if (r < 72) return lwpc_pkg::MODE_MARK;
    if (r < 84) return lwpc_pkg::MODE_CLEAR;
    if (r < 91) return lwpc_pkg::MODE_LIST;
    if (r < 97) return lwpc_pkg::MODE_FLUSH;
    return 3'($urandom_range(6, 7));
  endfunction

  task automatic random_requests(int n);
    logic [15:0] pg;
    for (int k = 0; k < n; k++) begin
      pg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : hot_pages[$urandom_range(0, 7)];
      send_request(pick_mode(), pg, 1'($urandom));
    end
  endtask

  task automatic test_directed();
    send_request(lwpc_pkg::MODE_GET, 16'h0000, 1'b0);
    send_request(lwpc_pkg::MODE_GET, 16'hffff, 1'b1);
    send_request(lwpc_pkg::MODE_GET, 16'hffff, 1'b0);
    send_request(lwpc_pkg::MODE_PUT, 16'h0000, 1'b0);
    send_request(lwpc_pkg::MODE_PUT, 16'h0000, 1'b1);
    send_request(lwpc_pkg::MODE_MARK, 16'hffff, 1'b0);
    send_request(lwpc_pkg::MODE_MARK, 16'h1234, 1'b0);
    send_request(lwpc_pkg::MODE_CLEAR, 16'h0000, 1'b0);
    send_request(lwpc_pkg::MODE_CLEAR, 16'h5555, 1'b1);
    send_request(lwpc_pkg::MODE_LIST, 16'haaaa, 1'b0);
    send_request(lwpc_pkg::MODE_FLUSH, 16'h5555, 1'b1);
    send_request(lwpc_pkg::MODE_LIST, 16'h0001, 1'b0);
    send_request(3'd6, 16'h8000, 1'b0);
    send_request(3'd7, 16'h7fff, 1'b1);
  endtask

  task automatic test_capacity_sweep();
    // fill dirty, then shrink so one insertion evicts several
    for (int i = 0; i < 17; i++) send_request(lwpc_pkg::MODE_PUT, 16'(16'h0100 + i), 1'b0);
    set_capacity(3);
    send_request(lwpc_pkg::MODE_GET, 16'h0200, 1'b1);
    send_request(lwpc_pkg::MODE_PUT, 16'h0201, 1'b0);
    set_capacity(0);
    send_request(lwpc_pkg::MODE_PUT, 16'h0300, 1'b0);
    send_request(lwpc_pkg::MODE_GET, 16'h0301, 1'b1);
    set_capacity(31);
    random_requests(40);
    set_capacity(1);
    random_requests(30);
    set_capacity(16);
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        random_requests(6);
        in_valid_i <= 1'b0;
      end
      begin
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end
    join
    // sender waits for every beat before going on
    while (expected_beats.size() != 0) @(posedge clk_i);
    random_requests(10);
  endtask

  task automatic test_random();
    set_capacity($urandom_range(2, 8));
    random_requests(120);
    set_capacity(16);
    random_requests(100);
    idle_on = 1'b0;
    random_requests(60);
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0; sh_dirty[i] = 1'b0; sh_rank[i] = 0; sh_page[i] = '0;
    end
    sh_occ = 0;
    sh_cap = lwpc_pkg::CAP_RESET;
    for (int i = 0; i < 8; i++) hot_pages[i] = 16'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity_sweep();
    test_backpressure();
    test_random();
    wait_drained();
    $display("covered %0d requests and %0d result beats over all modes,", n_items, n_beats);
    $display("capacity 0, 1, 3, 16, 31, eviction write-backs and long receiver hold-off");
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("%0d errors, %0d beats outstanding", n_errors, expected_beats.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
